// ----- rtl/lda_gibbs_topic_resampler_assert.svh -----
// Assertion macros shared by the topic resampler RTL.
// Needs clk_i in the scope of each use, and rst_ni for LGTR_ASSERT.
`ifndef LDA_GIBBS_TOPIC_RESAMPLER_ASSERT_SVH
`define LDA_GIBBS_TOPIC_RESAMPLER_ASSERT_SVH
`ifndef SYNTH
`define LGTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lgtr assertion failed");
`define LGTR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lgtr assertion failed");
`else
`define LGTR_ASSERT(lbl, prop)
`define LGTR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/lgtr_pkg.sv -----
// Types and constants of the LDA topic resampler.
// No dependencies.
package lgtr_pkg;

  localparam int NUM_TOPICS_DEF  = 64;
  localparam int VOCAB_WORDS_DEF = 4096;
  localparam int NUM_DOCS_DEF    = 1024;
  localparam int COUNT_BITS_DEF  = 20;

  localparam int TOPIC_W = 6;
  localparam int TOT_W   = 24;
  localparam int OP_W    = 64;
  localparam int DEN_W   = 46;
  localparam int WGT_W   = 48;
  localparam int VB_W    = 45;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOPICS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 2'd3;

  localparam logic [12:0] VOCAB_RST  = 13'd4096;
  localparam logic [6:0]  TOPICS_RST = 7'd64;
  localparam logic [31:0] ALPHA_RST  = 32'd32768;
  localparam logic [31:0] BETA_RST   = 32'd655;

  typedef struct packed {
    logic        func;
    logic [11:0] word_id;
    logic [9:0]  doc_id;
    logic [5:0]  old_topic;
    logic [31:0] random_u;
    logic [23:0] token_tag;
    logic        last_token;
  } in_t;

  typedef struct packed {
    logic [23:0] result_tag;
    logic [5:0]  new_topic;
    logic        sweep_done;
  } out_t;

  // Operands of one topic weight.
  typedef struct packed {
    logic [OP_W-1:0]  a;
    logic [OP_W-1:0]  b;
    logic [DEN_W-1:0] den;
  } wreq_t;

endpackage

// ----- rtl/lda_gibbs_topic_resampler.sv -----
// Top level of the LDA collapsed Gibbs topic resampler.
// Depends on lgtr_pkg, lgtr_weight_unit and lda_gibbs_topic_resampler_assert.svh.
//
//   port group   direction  handshake         payload
//   in           in         in_valid_i/ready  lgtr_pkg::in_t
//   out          out        out_valid_o/ready lgtr_pkg::out_t
//   cfg          in         cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// An add beat passes through the index reduction and one read-modify-write of
// the counts. A resample beat removes the token, computes one weight per topic
// in use in the shared weight unit (4 partial products and 48 division steps per
// topic; a weight that saturates or has a zero denominator skips the division),
// searches the topics in order and adds the token back. After reset a clearing
// pass over max(VOCAB_WORDS, NUM_DOCS)*NUM_TOPICS addresses zeroes the count
// memories; no input beat is taken during it. One beat is in work at a time; a
// finished result waits in the output register while the next input beat is taken.
`include "lda_gibbs_topic_resampler_assert.svh"
module lda_gibbs_topic_resampler #(
  parameter int NUM_TOPICS  = lgtr_pkg::NUM_TOPICS_DEF,
  parameter int VOCAB_WORDS = lgtr_pkg::VOCAB_WORDS_DEF,
  parameter int NUM_DOCS    = lgtr_pkg::NUM_DOCS_DEF,
  parameter int COUNT_BITS  = lgtr_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lgtr_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lgtr_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [lgtr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lgtr_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int WDEPTH = VOCAB_WORDS * NUM_TOPICS;
  localparam int DDEPTH = NUM_DOCS * NUM_TOPICS;
  localparam int CLRN   = (WDEPTH > DDEPTH) ? WDEPTH : DDEPTH;
  localparam int WA     = $clog2(WDEPTH);
  localparam int DA     = $clog2(DDEPTH);
  localparam int CW     = $clog2(CLRN);
  localparam int TW     = $clog2(NUM_TOPICS);
  localparam int SUMW   = lgtr_pkg::WGT_W + $clog2(NUM_TOPICS);
  localparam int MODW   = 21;
  localparam int TOTW   = lgtr_pkg::TOT_W;
  localparam int TOPW   = lgtr_pkg::TOPIC_W;
  localparam int WGW    = lgtr_pkg::WGT_W;
  localparam int VBW    = lgtr_pkg::VB_W;
  localparam int DENW   = lgtr_pkg::DEN_W;

  // Reciprocals for the index reduction; the 12-bit indices keep the
  // estimated quotient at most one below the true one.
  localparam int MOD_SH = 24;
  localparam int QW     = MOD_SH + 13;
  localparam logic [MOD_SH:0] W_REC = (MOD_SH+1)'((1 << MOD_SH) / VOCAB_WORDS);
  localparam logic [MOD_SH:0] D_REC = (MOD_SH+1)'((1 << MOD_SH) / NUM_DOCS);
  localparam logic [MOD_SH:0] T_REC = (MOD_SH+1)'((1 << MOD_SH) / NUM_TOPICS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_BASE  = 4'd3;
  localparam logic [3:0] S_URD   = 4'd4;
  localparam logic [3:0] S_UWR   = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WST   = 4'd7;
  localparam logic [3:0] S_WWAIT = 4'd8;
  localparam logic [3:0] S_TMUL0 = 4'd9;
  localparam logic [3:0] S_TMUL1 = 4'd10;
  localparam logic [3:0] S_SRD   = 4'd11;
  localparam logic [3:0] S_SCMP  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  // Configuration registers.
  logic [12:0] vocab_q;
  logic [6:0]  tiu_q;
  logic [31:0] alpha_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_q <= lgtr_pkg::VOCAB_RST;
      tiu_q   <= lgtr_pkg::TOPICS_RST;
      alpha_q <= lgtr_pkg::ALPHA_RST;
      beta_q  <= lgtr_pkg::BETA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lgtr_pkg::CFG_VOCAB:  vocab_q <= cfg_wdata_i[12:0];
        lgtr_pkg::CFG_TOPICS: tiu_q   <= cfg_wdata_i[6:0];
        lgtr_pkg::CFG_ALPHA:  alpha_q <= cfg_wdata_i;
        lgtr_pkg::CFG_BETA:   beta_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state.
  logic [3:0]     state_q, state_d;
  logic [CW-1:0]  clr_q, clr_d;
  logic [3:0]     mcnt_q, mcnt_d;
  logic           inc_q, inc_d;
  logic           fin_q, fin_d;
  logic [TW-1:0]  t_q, t_d;
  logic [TW-1:0]  nlast_q, nlast_d;
  logic           out_valid_q, out_valid_d;

  // Beat payload and work registers.
  lgtr_pkg::in_t  item_q;
  lgtr_pkg::out_t out_q;
  logic [MODW-1:0] rw_q, rd_q, rt_q, rw_d, rd_d, rt_d;
  logic [WA-1:0]   wbase_q;
  logic [DA-1:0]   dbase_q;
  logic [VBW-1:0]  vb_q;
  logic [SUMW-1:0] sum_q, sum_d;
  logic [63:0]     p0_q;
  logic [SUMW-1:0] thr_q;
  logic [SUMW-1:0] run_q, run_d;

  // Memories.
  logic [COUNT_BITS-1:0] wc_mem [WDEPTH];
  logic [COUNT_BITS-1:0] dc_mem [DDEPTH];
  logic [TOTW-1:0]       tc_mem [NUM_TOPICS];
  logic [WGW-1:0]        wt_mem [NUM_TOPICS];
  logic [COUNT_BITS-1:0] wc_rdata_q, dc_rdata_q;
  logic [TOTW-1:0]       tc_rdata_q;
  logic [WGW-1:0]        wt_rdata_q;

  logic                  wc_we, dc_we, tc_we;
  logic [WA-1:0]         wc_raddr, wc_waddr;
  logic [DA-1:0]         dc_raddr, dc_waddr;
  logic [TW-1:0]         tc_waddr;
  logic [COUNT_BITS-1:0] wc_wdata, dc_wdata;
  logic [TOTW-1:0]       tc_wdata;

  // Weight unit.
  logic            wu_start, wu_done;
  lgtr_pkg::wreq_t wu_req;
  logic [WGW-1:0]  wu_weight;

  lgtr_weight_unit u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wu_start),
    .req_i    (wu_req),
    .done_o   (wu_done),
    .weight_o (wu_weight)
  );

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [TOTW-1:0]       TOT_MAX = '1;

  logic [11:0]     w_ext, d_ext, t_ext;
  logic [QW-1:0]   qw_p, qd_p, qt_p;
  logic [MODW-1:0] rw_r, rd_r, rt_r;
  logic [SUMW-1:0] hp, run_new;
  logic [TW-1:0]   n_last;
  logic            clr_w, clr_d_en, clr_t;

  always_comb begin
    w_ext = item_q.word_id;
    d_ext = 12'(item_q.doc_id);
    t_ext = 12'(item_q.old_topic);
    qw_p  = QW'(w_ext) * QW'(W_REC);
    qd_p  = QW'(d_ext) * QW'(D_REC);
    qt_p  = QW'(t_ext) * QW'(T_REC);
    rw_r  = MODW'(w_ext) - rw_q * MODW'(VOCAB_WORDS);
    rd_r  = MODW'(d_ext) - rd_q * MODW'(NUM_DOCS);
    rt_r  = MODW'(t_ext) - rt_q * MODW'(NUM_TOPICS);

    if (tiu_q == '0) begin
      n_last = '0;
    end else if (int'(tiu_q) > NUM_TOPICS) begin
      n_last = TW'(NUM_TOPICS - 1);
    end else begin
      n_last = TW'(tiu_q - 7'd1);
    end

    hp      = SUMW'(sum_q[SUMW-1:32]) * SUMW'(item_q.random_u);
    run_new = run_q + SUMW'(wt_rdata_q);

    clr_w    = int'(clr_q) < WDEPTH;
    clr_d_en = int'(clr_q) < DDEPTH;
    clr_t    = int'(clr_q) < NUM_TOPICS;

    wc_raddr = wbase_q + WA'(t_q);
    dc_raddr = dbase_q + DA'(t_q);

    wu_req.a   = (64'(dc_rdata_q) << 16) + 64'(alpha_q);
    wu_req.b   = (64'(wc_rdata_q) << 16) + 64'(beta_q);
    wu_req.den = (DENW'(tc_rdata_q) << 16) + DENW'(vb_q);
    wu_start   = (state_q == S_WST);
  end

  // Write ports: the clearing pass, or the read-modify-write of one token.
  always_comb begin
    if (state_q == S_CLEAR) begin
      wc_we    = clr_w;
      dc_we    = clr_d_en;
      tc_we    = clr_t;
      wc_waddr = WA'(clr_q);
      dc_waddr = DA'(clr_q);
      tc_waddr = TW'(clr_q);
      wc_wdata = '0;
      dc_wdata = '0;
      tc_wdata = '0;
    end else begin
      wc_we    = (state_q == S_UWR);
      dc_we    = (state_q == S_UWR);
      tc_we    = (state_q == S_UWR);
      wc_waddr = wc_raddr;
      dc_waddr = dc_raddr;
      tc_waddr = t_q;
      if (inc_q) begin
        wc_wdata = (wc_rdata_q == CNT_MAX) ? wc_rdata_q : wc_rdata_q + 1'b1;
        dc_wdata = (dc_rdata_q == CNT_MAX) ? dc_rdata_q : dc_rdata_q + 1'b1;
        tc_wdata = (tc_rdata_q == TOT_MAX) ? tc_rdata_q : tc_rdata_q + 1'b1;
      end else begin
        wc_wdata = (wc_rdata_q == '0) ? wc_rdata_q : wc_rdata_q - 1'b1;
        dc_wdata = (dc_rdata_q == '0) ? dc_rdata_q : dc_rdata_q - 1'b1;
        tc_wdata = (tc_rdata_q == '0) ? tc_rdata_q : tc_rdata_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wc_we) wc_mem[wc_waddr] <= wc_wdata;
    wc_rdata_q <= wc_mem[wc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dc_we) dc_mem[dc_waddr] <= dc_wdata;
    dc_rdata_q <= dc_mem[dc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tc_we) tc_mem[tc_waddr] <= tc_wdata;
    tc_rdata_q <= tc_mem[t_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WWAIT && wu_done) wt_mem[t_q] <= wu_weight;
    wt_rdata_q <= wt_mem[t_q];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mcnt_d      = mcnt_q;
    inc_d       = inc_q;
    fin_d       = fin_q;
    t_d         = t_q;
    nlast_d     = nlast_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rw_d        = rw_q;
    rd_d        = rd_q;
    rt_d        = rt_q;
    sum_d       = sum_q;
    run_d       = run_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (int'(clr_q) == CLRN - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          rw_d    = '0;
          rd_d    = '0;
          rt_d    = '0;
          mcnt_d  = 4'd1;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // Index reduction: a quotient estimate by reciprocal multiplication,
        // then one correcting subtraction of the remainder.
        if (mcnt_q != '0) begin
          rw_d   = MODW'(qw_p >> MOD_SH);
          rd_d   = MODW'(qd_p >> MOD_SH);
          rt_d   = MODW'(qt_p >> MOD_SH);
          mcnt_d = mcnt_q - 4'd1;
        end else begin
          rw_d    = (rw_r >= MODW'(VOCAB_WORDS)) ? rw_r - MODW'(VOCAB_WORDS) : rw_r;
          rd_d    = (rd_r >= MODW'(NUM_DOCS)) ? rd_r - MODW'(NUM_DOCS) : rd_r;
          rt_d    = (rt_r >= MODW'(NUM_TOPICS)) ? rt_r - MODW'(NUM_TOPICS) : rt_r;
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        t_d     = TW'(rt_q);
        nlast_d = n_last;
        inc_d   = !item_q.func;
        fin_d   = !item_q.func;
        state_d = S_URD;
      end
      S_URD: state_d = S_UWR;
      S_UWR: begin
        if (fin_q) begin
          state_d = S_DONE;
        end else begin
          t_d     = '0;
          sum_d   = '0;
          state_d = S_WRD;
        end
      end
      S_WRD: state_d = S_WST;
      S_WST: state_d = S_WWAIT;
      S_WWAIT: begin
        if (wu_done) begin
          sum_d = sum_q + SUMW'(wu_weight);
          if (t_q == nlast_q) begin
            state_d = S_TMUL0;
          end else begin
            t_d     = t_q + 1'b1;
            state_d = S_WRD;
          end
        end
      end
      S_TMUL0: state_d = S_TMUL1;
      S_TMUL1: begin
        t_d     = '0;
        run_d   = '0;
        state_d = S_SRD;
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        run_d = run_new;
        if (run_new >= thr_q || t_q == nlast_q) begin
          inc_d   = 1'b1;
          fin_d   = 1'b1;
          state_d = S_URD;
        end else begin
          t_d     = t_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      mcnt_q      <= '0;
      inc_q       <= 1'b0;
      fin_q       <= 1'b0;
      t_q         <= '0;
      nlast_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      mcnt_q      <= mcnt_d;
      inc_q       <= inc_d;
      fin_q       <= fin_d;
      t_q         <= t_d;
      nlast_q     <= nlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    rw_q  <= rw_d;
    rd_q  <= rd_d;
    rt_q  <= rt_d;
    sum_q <= sum_d;
    run_q <= run_d;
    if (state_q == S_BASE) begin
      wbase_q <= WA'(int'(rw_q) * NUM_TOPICS);
      dbase_q <= DA'(int'(rd_q) * NUM_TOPICS);
      vb_q    <= VBW'(vocab_q) * VBW'(beta_q);
    end
    if (state_q == S_TMUL0) begin
      p0_q <= 64'(sum_q[31:0]) * 64'(item_q.random_u);
    end
    if (state_q == S_TMUL1) begin
      thr_q <= hp + SUMW'(p0_q >> 32);
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.result_tag <= item_q.token_tag;
      out_q.new_topic  <= TOPW'(t_q);
      out_q.sweep_done <= item_q.last_token;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LGTR_ASSERT(a_done_only_waiting, wu_done |-> state_q == S_WWAIT)
  `LGTR_ASSERT(a_no_write_in_search,
    (state_q == S_SRD || state_q == S_SCMP) |-> !wc_we && !dc_we && !tc_we)
  `LGTR_ASSERT(a_search_in_range, state_q == S_SCMP |-> t_q <= nlast_q)
  `LGTR_ASSERT(a_result_loaded, state_q == S_DONE && !out_valid_q |=> out_valid_q)
  `LGTR_ASSERT_ALWAYS(a_no_take_while_clear, state_q == S_CLEAR |-> !in_ready_o)

endmodule

// ----- rtl/lgtr_weight_unit.sv -----
// Multi-cycle topic weight unit: a*b*2^16/den with saturation, zero for a zero den.
// Depends on lgtr_pkg and lda_gibbs_topic_resampler_assert.svh.
`include "lda_gibbs_topic_resampler_assert.svh"
module lgtr_weight_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  lgtr_pkg::wreq_t               req_i,
  output logic                          done_o,
  output logic [lgtr_pkg::WGT_W-1:0]    weight_o
);

  localparam int DW = lgtr_pkg::DEN_W;
  localparam int WW = lgtr_pkg::WGT_W;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_CHK  = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;

  logic [2:0]      state_q, state_d;
  lgtr_pkg::wreq_t req_q;
  logic [1:0]      k_q, k_d;
  logic [127:0]    acc_q, acc_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [WW-1:0]   low_q, low_d;
  logic [WW-1:0]   quo_q, quo_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [WW-1:0]   wgt_q, wgt_d;

  logic [31:0]  mx, my;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  rtop;
  logic [DW:0]  rs;

  always_comb begin
    mx = k_q[0] ? req_q.a[63:32] : req_q.a[31:0];
    my = k_q[1] ? req_q.b[63:32] : req_q.b[31:0];
    pp = 64'(mx) * 64'(my);
    case (k_q)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = 128'(pp) << 32;
    endcase
    rtop = acc_q[95:32];
    rs   = {rem_q, low_q[WW-1]};
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    low_d   = low_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    wgt_d   = wgt_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          acc_d   = '0;
          k_d     = 2'd0;
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        acc_d = acc_q + pp_sh;
        k_d   = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = U_CHK;
        end
      end
      U_CHK: begin
        if (req_q.den == '0) begin
          wgt_d   = '0;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else if (acc_q[127:96] != '0 || rtop >= 64'(req_q.den)) begin
          wgt_d   = '1;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else begin
          rem_d   = rtop[DW-1:0];
          low_d   = {acc_q[31:0], 16'd0};
          quo_d   = '0;
          cnt_d   = 6'(WW - 1);
          state_d = U_DIV;
        end
      end
      U_DIV: begin
        // One quotient bit per cycle, restoring division.
        if (rs >= (DW+1)'(req_q.den)) begin
          rem_d = DW'(rs - (DW+1)'(req_q.den));
          quo_d = {quo_q[WW-2:0], 1'b1};
        end else begin
          rem_d = rs[DW-1:0];
          quo_d = {quo_q[WW-2:0], 1'b0};
        end
        low_d = low_q << 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          wgt_d   = quo_d;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && start_i) begin
      req_q <= req_i;
    end
    k_q   <= k_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    wgt_q <= wgt_d;
  end

  assign done_o   = done_q;
  assign weight_o = wgt_q;

  `LGTR_ASSERT(a_rem_below_den, state_q == U_DIV |-> rem_q < req_q.den)
  `LGTR_ASSERT(a_done_from_work, done_q |-> $past(state_q) == U_CHK || $past(state_q) == U_DIV)
  `LGTR_ASSERT(a_mul_to_chk, state_q == U_MUL && k_q == 2'd3 |=> state_q == U_CHK)

endmodule
